// ===== hdl/tlbsa_pkg.sv =====
package tlbsa_pkg;

	localparam int OP_W     = 2;
	localparam int PAGE_W   = 11;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 2;

	// The page-full bitmap is kept in words of this many pages.
	localparam int FULL_WORD_BITS = 32;
	localparam int FULL_WORD_LOG  = 5;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_DELETE = 2'd1;
	localparam op_t OP_CHECK  = 2'd2;
	localparam op_t OP_NEXT   = 2'd3;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_NOSPACE = 2'd2;
	localparam status_t ST_RANGE   = 2'd3;

endpackage

// ===== hdl/two_level_bitmap_slot_allocator.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   op, page_index, slot_index
// rsp      out        rsp_valid/rsp_stall   status, result_page, result_slot, high_water_page
//
// Insert scans the page-full words one at a time, then reads and writes the slot word of the page found.
// Delete, check and next read the slot word and then act on it; a position out of range goes straight to the result.
// Insert's serial scan of the page-full word memory goes through the shared bit finder.
// After reset a clearing pass over every page runs before the first request is taken.
// A waiting result sits in the output register and a new request can still be taken.
module two_level_bitmap_slot_allocator #(
	parameter int PAGES = 1024,
	parameter int SLOTS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  tlbsa_pkg::op_t                      op,
	input  logic [tlbsa_pkg::PAGE_W-1:0]        page_index,
	input  logic signed [tlbsa_pkg::SLOT_W-1:0] slot_index,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output tlbsa_pkg::status_t                  status,
	output logic [tlbsa_pkg::PAGE_W-1:0]        result_page,
	output logic [tlbsa_pkg::SLOT_W-1:0]        result_slot,
	output logic [tlbsa_pkg::PAGE_W-1:0]        high_water_page
);

	localparam int FB   = tlbsa_pkg::FULL_WORD_BITS;
	localparam int FBL  = tlbsa_pkg::FULL_WORD_LOG;
	localparam int PGW  = tlbsa_pkg::PAGE_W;
	localparam int SLW  = tlbsa_pkg::SLOT_W;
	localparam int PW   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int SW   = $clog2(SLOTS);
	localparam int FW   = (PAGES + FB - 1) / FB;
	localparam int FWA  = (FW > 1) ? $clog2(FW) : 1;
	localparam int UW   = (SLOTS > FB) ? SLOTS : FB;
	localparam int IW   = $clog2(UW);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FSCAN = 3'd2;
	localparam logic [2:0] S_IRD   = 3'd3;
	localparam logic [2:0] S_IWR   = 3'd4;
	localparam logic [2:0] S_PRD   = 3'd5;
	localparam logic [2:0] S_PEX   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [SLOTS-1:0] slot_mem [PAGES];
	logic [FB-1:0]    full_mem [FW];

	logic [2:0]     state_q;
	logic [PW-1:0]  clr_q;
	logic [FWA-1:0] w_q;
	logic [FWA-1:0] fw_s1;
	logic           fv_s1;
	logic [PW:0]    hw_q;
	logic           rsp_valid_q;

	tlbsa_pkg::op_t            op_q;
	logic [PW-1:0]             p_q;
	logic signed [SLW-1:0]     s_q;
	logic [SLOTS-1:0]          sdata_q;
	logic [FB-1:0]             fdata_q;
	tlbsa_pkg::status_t        r_status_q;
	logic [PGW-1:0]            r_page_q;
	logic [SLW-1:0]            r_slot_q;
	tlbsa_pkg::status_t        o_status_q;
	logic [PGW-1:0]            o_page_q;
	logic [SLW-1:0]            o_slot_q;
	logic [PGW-1:0]            o_hw_q;

	logic             req_take;
	logic             rsp_load;
	logic             page_ok;
	logic             slot_ok;
	logic             next_ok;
	logic [FB-1:0]    fmask;
	logic [FB-1:0]    fword_m;
	logic [SLOTS-1:0] nmask;
	logic [UW-1:0]    enc_in;
	logic             enc_hit;
	logic [IW-1:0]    enc_idx;
	logic             found_now;
	logic [FWA-1:0]   p_word;
	logic [FBL-1:0]   p_bit;
	logic [SW-1:0]    s_bit;
	logic [SW-1:0]    ins_bit;
	logic [SLOTS-1:0] ins_map;
	logic             slot_set;

	logic             s_re;
	logic             s_we;
	logic [PW-1:0]    s_waddr;
	logic [SLOTS-1:0] s_wdata;
	logic             f_re;
	logic [FWA-1:0]   f_raddr;
	logic             f_we;
	logic [FWA-1:0]   f_waddr;
	logic [FB-1:0]    f_wdata;

	assign req_stall       = (state_q != S_IDLE);
	assign req_take        = req_valid && !req_stall;
	assign rsp_load        = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid       = rsp_valid_q;
	assign status          = o_status_q;
	assign result_page     = o_page_q;
	assign result_slot     = o_slot_q;
	assign high_water_page = o_hw_q;

	assign page_ok = (page_index >= PGW'(1)) && (int'(page_index) <= PAGES);
	assign slot_ok = (slot_index >= 0) && (int'(slot_index) < SLOTS);
	assign next_ok = (slot_index >= -1) && (int'(slot_index) < SLOTS);

	assign p_word   = FWA'(p_q >> FBL);
	assign p_bit    = FBL'(p_q);
	assign s_bit    = SW'(s_q[SLW-2:0]);
	assign slot_set = sdata_q[s_bit];
	assign ins_bit  = SW'(enc_idx);
	assign ins_map  = sdata_q | (SLOTS'(1) << ins_bit);
	assign fword_m  = fdata_q | fmask;

	always_comb begin
		for (int b = 0; b < FB; b++) begin
			fmask[b] = (int'(fw_s1) * FB + b >= PAGES);
		end
		for (int i = 0; i < SLOTS; i++) begin
			nmask[i] = (i > int'(s_q));
		end
	end

	// Shared lowest-set-bit finder used by every search.
	always_comb begin
		unique case (state_q)
			S_FSCAN: enc_in = UW'(~fword_m);
			S_IWR:   enc_in = UW'(~sdata_q);
			S_PEX:   enc_in = UW'(sdata_q & nmask);
			default: enc_in = '0;
		endcase
		enc_hit = 1'b0;
		enc_idx = '0;
		for (int i = UW - 1; i >= 0; i--) begin
			if (enc_in[i]) begin
				enc_hit = 1'b1;
				enc_idx = IW'(i);
			end
		end
	end

	assign found_now = (state_q == S_FSCAN) && fv_s1 && enc_hit;

	always_comb begin
		s_re    = (state_q == S_IRD) || (state_q == S_PRD);
		f_re    = ((state_q == S_FSCAN) && !found_now) || (state_q == S_PRD);
		f_raddr = (state_q == S_FSCAN) ? w_q : p_word;
		s_we    = 1'b0;
		s_waddr = p_q;
		s_wdata = '0;
		f_we    = 1'b0;
		f_waddr = p_word;
		f_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
				f_we    = (int'(clr_q) < FW);
				f_waddr = FWA'(clr_q);
			end
			S_IWR: begin
				s_we    = 1'b1;
				s_wdata = ins_map;
				f_we    = &ins_map;
				f_wdata = fdata_q | (FB'(1) << p_bit);
			end
			S_PEX: begin
				s_we    = (op_q == tlbsa_pkg::OP_DELETE) && slot_set;
				s_wdata = sdata_q & ~(SLOTS'(1) << s_bit);
				f_we    = s_we;
				f_wdata = fdata_q & ~(FB'(1) << p_bit);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			slot_mem[s_waddr] <= s_wdata;
		end
		if (s_re) begin
			sdata_q <= slot_mem[p_q];
		end
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			full_mem[f_waddr] <= f_wdata;
		end
		if (f_re) begin
			fdata_q <= full_mem[f_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			w_q         <= '0;
			fw_s1       <= '0;
			fv_s1       <= 1'b0;
			hw_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PW'(1);
					if (int'(clr_q) == PAGES - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_take) begin
						w_q   <= '0;
						fv_s1 <= 1'b0;
						if (op == tlbsa_pkg::OP_INSERT) begin
							state_q <= S_FSCAN;
						end else if (!page_ok || ((op == tlbsa_pkg::OP_NEXT) ? !next_ok : !slot_ok)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_PRD;
						end
					end
				end
				S_FSCAN: begin
					if (found_now) begin
						state_q <= S_IRD;
					end else if (fv_s1 && (int'(fw_s1) == FW - 1)) begin
						state_q <= S_DONE;
					end else begin
						fw_s1 <= w_q;
						fv_s1 <= 1'b1;
						if (int'(w_q) != FW - 1) begin
							w_q <= w_q + FWA'(1);
						end
					end
				end
				S_IRD: begin
					state_q <= S_IWR;
				end
				S_IWR: begin
					if ({1'b0, p_q} + (PW+1)'(1) > hw_q) begin
						hw_q <= {1'b0, p_q} + (PW+1)'(1);
					end
					state_q <= S_DONE;
				end
				S_PRD: begin
					state_q <= S_PEX;
				end
				S_PEX: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q       <= op;
			p_q        <= PW'(page_index - PGW'(1));
			s_q        <= slot_index;
			r_status_q <= tlbsa_pkg::ST_RANGE;
			r_page_q   <= page_index;
			r_slot_q   <= (op == tlbsa_pkg::OP_NEXT) ? SLW'(SLOTS) : '0;
		end
		if (state_q == S_FSCAN) begin
			if (found_now) begin
				p_q <= PW'(int'(fw_s1) * FB + int'(enc_idx));
			end else if (fv_s1 && (int'(fw_s1) == FW - 1)) begin
				r_status_q <= tlbsa_pkg::ST_NOSPACE;
				r_page_q   <= '0;
				r_slot_q   <= SLW'(SLOTS);
			end
		end
		if (state_q == S_IWR) begin
			r_status_q <= tlbsa_pkg::ST_OK;
			r_page_q   <= PGW'({1'b0, p_q} + (PW+1)'(1));
			r_slot_q   <= SLW'(ins_bit);
		end
		if (state_q == S_PEX) begin
			if (op_q == tlbsa_pkg::OP_NEXT) begin
				r_status_q <= tlbsa_pkg::ST_OK;
				r_slot_q   <= enc_hit ? SLW'(enc_idx) : SLW'(SLOTS);
			end else begin
				r_status_q <= slot_set ? tlbsa_pkg::ST_OK : tlbsa_pkg::ST_EMPTY;
				r_slot_q   <= '0;
			end
		end
		if (rsp_load) begin
			o_status_q <= r_status_q;
			o_page_q   <= r_page_q;
			o_slot_q   <= r_slot_q;
			o_hw_q     <= PGW'(hw_q);
		end
	end

endmodule

// ===== hdl/tlbsa_checker.sv =====
module tlbsa_checker #(
	parameter int SLOTS = 32
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_stall,
	input tlbsa_pkg::op_t                      op,
	input logic [tlbsa_pkg::PAGE_W-1:0]        page_index,
	input logic signed [tlbsa_pkg::SLOT_W-1:0] slot_index,
	input logic                                rsp_valid,
	input logic                                rsp_stall,
	input tlbsa_pkg::status_t                  status,
	input logic [tlbsa_pkg::PAGE_W-1:0]        result_page,
	input logic [tlbsa_pkg::SLOT_W-1:0]        result_slot,
	input logic [tlbsa_pkg::PAGE_W-1:0]        high_water_page
);

	localparam int SLW = tlbsa_pkg::SLOT_W;

	// A stalled result holds its value until the transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(result_page)
			&& $stable(result_slot) && $stable(high_water_page))
		else $error("stalled result changed");

	// The block works on one request at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	a_nospace: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == tlbsa_pkg::ST_NOSPACE |->
			result_page == '0 && result_slot == SLW'(SLOTS))
		else $error("no-space result carries a position");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == tlbsa_pkg::ST_EMPTY |-> result_slot == '0)
		else $error("empty-slot result carries a slot");

endmodule

bind two_level_bitmap_slot_allocator tlbsa_checker #(.SLOTS(SLOTS)) u_tlbsa_checker (.*);
